// ===== hdl/ps2mt_pkg.sv =====
// Shared types, constants and helpers for the PS/2 mouse packet tracker.
package ps2mt_pkg;

  localparam int POS_FRAC_BITS_DEF  = 8;
  localparam int GAIN_FRAC_BITS_DEF = 12;

  localparam int BYTE_W     = 8;
  localparam int SCREEN_W   = 13;
  localparam int GAIN_W     = 16;
  localparam int MOVE_W     = 20;
  localparam int COORD_W    = 12;
  localparam int BTN_W      = 3;
  localparam int BTN_IDX_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SYNC_BIT = 3;
  localparam int SCREEN_MAX = 4096;

  typedef logic [BYTE_W-1:0]          byte_t;
  typedef logic [SCREEN_W-1:0]        screen_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic signed [MOVE_W-1:0]   move_t;
  typedef logic [COORD_W-1:0]         coord_t;
  typedef logic [BTN_W-1:0]           btn_t;
  typedef logic [BTN_IDX_W-1:0]       btn_idx_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  // register indexes of the configuration port
  localparam cfg_idx_t CFG_ENABLE   = 3'd0;
  localparam cfg_idx_t CFG_SCREEN_W = 3'd1;
  localparam cfg_idx_t CFG_SCREEN_H = 3'd2;
  localparam cfg_idx_t CFG_X_GAIN   = 3'd3;
  localparam cfg_idx_t CFG_Y_GAIN   = 3'd4;

  localparam screen_t RST_SCREEN_W = 13'd80;
  localparam screen_t RST_SCREEN_H = 13'd25;
  localparam gain_t   RST_GAIN     = 16'd614;

  // event kinds
  localparam logic EV_MOVE   = 1'b0;
  localparam logic EV_BUTTON = 1'b1;

  typedef enum logic [1:0] {
    BP_FIRST  = 2'd0,
    BP_SECOND = 2'd1,
    BP_THIRD  = 2'd2
  } bpos_t;

  // effective screen limit: zero acts as one, anything above the max saturates
  function automatic screen_t lim_of(input screen_t v);
    screen_t r;
    if (v == '0) begin
      r = screen_t'(1);
    end else if (v > screen_t'(SCREEN_MAX)) begin
      r = screen_t'(SCREEN_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/ps2mt_if.sv =====
// Valid/ready channel interfaces for input bytes and result events.
interface ps2mt_in_if;
  import ps2mt_pkg::*;

  logic  valid;
  logic  ready;
  logic  aux_flag;
  byte_t data_byte;

  modport source(output valid, aux_flag, data_byte, input ready);
  modport sink(input valid, aux_flag, data_byte, output ready);
endinterface

interface ps2mt_out_if;
  import ps2mt_pkg::*;

  logic     valid;
  logic     ready;
  logic     event_kind;
  coord_t   pointer_x;
  coord_t   pointer_y;
  move_t    move_x;
  move_t    move_y;
  btn_idx_t button_index;
  logic     button_down;
  logic     last_event;

  modport source(output valid, event_kind, pointer_x, pointer_y, move_x, move_y,
                 button_index, button_down, last_event, input ready);
  modport sink(input valid, event_kind, pointer_x, pointer_y, move_x, move_y,
               button_index, button_down, last_event, output ready);
endinterface

// ===== hdl/ps2_mouse_packet_tracker.sv =====
// A byte transfer shows its first result after the input register, then the
// event register. Results leave one per cycle while out_ch.ready is high.
// Throughput: one byte per cycle while each byte yields at most one result and
// no stall; a byte with more results (up to three) holds input until they all leave.
// Reset (synchronous, rst_n low): packet alignment and buttons cleared,
// registers to defaults, pointer to the center of the default screen.
module ps2_mouse_packet_tracker #(
  parameter int POS_FRAC_BITS  = ps2mt_pkg::POS_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS = ps2mt_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ps2mt_in_if.sink              in_ch,
  ps2mt_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  ps2mt_pkg::cfg_idx_t   cfg_index,
  input  ps2mt_pkg::cfg_data_t  cfg_data
);
  import ps2mt_pkg::*;

  localparam int LSH    = (POS_FRAC_BITS > GAIN_FRAC_BITS) ? POS_FRAC_BITS - GAIN_FRAC_BITS : 0;
  localparam int RSH    = (GAIN_FRAC_BITS > POS_FRAC_BITS) ? GAIN_FRAC_BITS - POS_FRAC_BITS : 0;
  localparam int PROD_W = BYTE_W + GAIN_W + 1;
  localparam int EXT_W  = PROD_W + LSH;
  localparam int POS_W  = COORD_W + POS_FRAC_BITS;
  localparam int SUM_W  = ((POS_W > MOVE_W) ? POS_W : MOVE_W) + 2;

  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(2 ** (MOVE_W - 1) - 1);
  localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(-(2 ** (MOVE_W - 1)));

  localparam logic [POS_W-1:0] POS_X_RST =
    POS_W'(lim_of(RST_SCREEN_W) / 2) << POS_FRAC_BITS;
  localparam logic [POS_W-1:0] POS_Y_RST =
    POS_W'(lim_of(RST_SCREEN_H) / 2) << POS_FRAC_BITS;

  // scale a signed delta by a gain, fixed-point convert and saturate
  function automatic move_t scale(input byte_t raw, input gain_t gain, input logic neg);
    logic signed [PROD_W-1:0] d;
    logic signed [PROD_W-1:0] g;
    logic signed [PROD_W-1:0] p;
    logic signed [EXT_W-1:0]  e;
    move_t                    r;
    d = PROD_W'($signed(raw));
    g = PROD_W'($signed({1'b0, gain}));
    p = d * g;
    if (neg) begin
      p = -p;
    end
    e = EXT_W'(p);
    e = (e <<< LSH) >>> RSH;
    if (e > SAT_HI) begin
      r = move_t'(SAT_HI);
    end else if (e < SAT_LO) begin
      r = move_t'(SAT_LO);
    end else begin
      r = e[MOVE_W-1:0];
    end
    return r;
  endfunction

  // add a delta to a position and clamp to [0, lim) with zero fraction at the top
  function automatic logic [POS_W-1:0] clamp(input logic [POS_W-1:0] pos, input move_t dm,
                                             input screen_t lim);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] top;
    logic [POS_W-1:0]        r;
    s   = $signed(SUM_W'(pos)) + SUM_W'(dm);
    top = $signed(SUM_W'(lim)) <<< POS_FRAC_BITS;
    if (s < 0) begin
      r = '0;
    end else if (s >= top) begin
      r = POS_W'(lim - screen_t'(1)) << POS_FRAC_BITS;
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic    enable_r;
  screen_t scr_w_r, scr_h_r;
  gain_t   x_gain_r, y_gain_r;

  // input stage
  logic  in_vld_r;
  logic  aux_r;
  byte_t byte_r;
  move_t sx_r, sy_r;

  // tracker state
  bpos_t            bpos_r, bpos_nxt;
  btn_t             btn_prev_r, btn_nxt;
  byte_t            xraw_r, xraw_nxt, x_src;
  logic [POS_W-1:0] posx_r, posx_nxt, posy_r, posy_nxt;
  logic             mv_nxt;

  // pending events of one byte
  logic             mv_r;
  btn_t             bmask_r, bmask_rest;
  btn_t             bval_r;
  move_t            ev_mx_r, ev_my_r;
  logic [POS_W-1:0] ev_px_r, ev_py_r;

  logic     busy, last, out_fire, free, process;
  btn_idx_t sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      scr_w_r  <= RST_SCREEN_W;
      scr_h_r  <= RST_SCREEN_H;
      x_gain_r <= RST_GAIN;
      y_gain_r <= RST_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:   enable_r <= cfg_data[0];
        CFG_SCREEN_W: scr_w_r  <= cfg_data[SCREEN_W-1:0];
        CFG_SCREEN_H: scr_h_r  <= cfg_data[SCREEN_W-1:0];
        CFG_X_GAIN:   x_gain_r <= cfg_data[GAIN_W-1:0];
        CFG_Y_GAIN:   y_gain_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // event selection: move first, then buttons in index order
  always_comb begin
    bmask_rest = bmask_r & (bmask_r - btn_t'(1));
    priority if (bmask_r[0]) begin
      sel = btn_idx_t'(0);
    end else if (bmask_r[1]) begin
      sel = btn_idx_t'(1);
    end else begin
      sel = btn_idx_t'(2);
    end
    busy     = mv_r | (|bmask_r);
    last     = mv_r ? (bmask_r == '0) : (bmask_rest == '0);
    out_fire = busy & out_ch.ready;
    free     = !busy || (out_fire && last);
    process  = in_vld_r && free;
  end

  assign in_ch.ready = !in_vld_r || free;

  assign out_ch.valid        = busy;
  assign out_ch.event_kind   = mv_r ? EV_MOVE : EV_BUTTON;
  assign out_ch.pointer_x    = ev_px_r[POS_W-1 -: COORD_W];
  assign out_ch.pointer_y    = ev_py_r[POS_W-1 -: COORD_W];
  assign out_ch.move_x       = mv_r ? ev_mx_r : '0;
  assign out_ch.move_y       = mv_r ? ev_my_r : '0;
  assign out_ch.button_index = mv_r ? '0 : sel;
  assign out_ch.button_down  = mv_r ? 1'b0 : bval_r[sel];
  assign out_ch.last_event   = last;

  // take the X byte straight from the input register when it is processed this cycle
  assign x_src = (in_vld_r && enable_r && aux_r && bpos_r == BP_SECOND) ? byte_r : xraw_r;

  // input stage: scale both deltas up front so the state update only adds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (process) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      aux_r  <= in_ch.aux_flag;
      byte_r <= in_ch.data_byte;
      sx_r   <= scale(x_src, x_gain_r, 1'b0);
      sy_r   <= scale(in_ch.data_byte, y_gain_r, 1'b1);
    end
  end

  always_comb begin
    bpos_nxt = bpos_r;
    btn_nxt  = btn_prev_r;
    xraw_nxt = xraw_r;
    posx_nxt = posx_r;
    posy_nxt = posy_r;
    mv_nxt   = 1'b0;
    if (enable_r && aux_r) begin
      unique case (bpos_r)
        BP_FIRST: begin
          btn_nxt  = byte_r[BTN_W-1:0];
          // drop alignment when the sync bit is missing
          bpos_nxt = byte_r[SYNC_BIT] ? BP_SECOND : BP_FIRST;
        end
        BP_SECOND: begin
          xraw_nxt = byte_r;
          bpos_nxt = BP_THIRD;
        end
        BP_THIRD: begin
          mv_nxt   = 1'b1;
          bpos_nxt = BP_FIRST;
          posx_nxt = clamp(posx_r, sx_r, lim_of(scr_w_r));
          posy_nxt = clamp(posy_r, sy_r, lim_of(scr_h_r));
        end
        default: bpos_nxt = BP_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r     <= BP_FIRST;
      btn_prev_r <= '0;
      posx_r     <= POS_X_RST;
      posy_r     <= POS_Y_RST;
      mv_r       <= 1'b0;
      bmask_r    <= '0;
    end else if (process) begin
      bpos_r     <= bpos_nxt;
      btn_prev_r <= btn_nxt;
      posx_r     <= posx_nxt;
      posy_r     <= posy_nxt;
      mv_r       <= mv_nxt;
      bmask_r    <= btn_nxt ^ btn_prev_r;
    end else if (out_fire) begin
      // advance to the next pending event
      if (mv_r) begin
        mv_r <= 1'b0;
      end else begin
        bmask_r <= bmask_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      xraw_r  <= xraw_nxt;
      bval_r  <= btn_nxt;
      ev_mx_r <= sx_r;
      ev_my_r <= sy_r;
      ev_px_r <= posx_nxt;
      ev_py_r <= posy_nxt;
    end
  end

endmodule

// ===== hdl/ps2mt_checker.sv =====
// Port-level assertions for the PS/2 mouse packet tracker, with its bind.
module ps2mt_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  event_kind,
  input ps2mt_pkg::coord_t     pointer_x,
  input ps2mt_pkg::coord_t     pointer_y,
  input ps2mt_pkg::move_t      move_x,
  input ps2mt_pkg::move_t      move_y,
  input ps2mt_pkg::btn_idx_t   button_index,
  input logic                  button_down,
  input logic                  last_event
);
  import ps2mt_pkg::*;

  logic out_fire;
  assign out_fire = out_valid && out_ready;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result withdrawn");

  a_stall_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(event_kind) && $stable(pointer_x) &&
      $stable(pointer_y) && $stable(move_x) && $stable(move_y) &&
      $stable(button_index) && $stable(button_down) && $stable(last_event))
    else $error("stalled result changed");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !last_event |=> out_valid && event_kind == EV_BUTTON &&
      pointer_x == $past(pointer_x) && pointer_y == $past(pointer_y))
    else $error("events of one byte broken up or pointer moved within them");

  a_button_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !last_event && event_kind == EV_BUTTON |=>
      button_index > $past(button_index))
    else $error("button events out of index order");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_kind   (out_ch.event_kind),
  .pointer_x    (out_ch.pointer_x),
  .pointer_y    (out_ch.pointer_y),
  .move_x       (out_ch.move_x),
  .move_y       (out_ch.move_y),
  .button_index (out_ch.button_index),
  .button_down  (out_ch.button_down),
  .last_event   (out_ch.last_event)
);
